>>> src/srsc_pkg.sv
`timescale 1ns / 1ps
package srsc_pkg;

  localparam int unsigned DIV_W = 52;
  localparam int unsigned QUO_W = 64;
  localparam logic [19:0] MICRO_SCALE = 20'd1000000;

  localparam logic [2:0] TYPE_I16 = 3'd0;
  localparam logic [2:0] TYPE_U16 = 3'd1;
  localparam logic [2:0] TYPE_I32 = 3'd2;
  localparam logic [2:0] TYPE_U32 = 3'd3;

  localparam logic [1:0] IDX_NUM = 2'd0;
  localparam logic [1:0] IDX_DEN = 2'd1;
  localparam logic [1:0] IDX_OFF = 2'd2;
  localparam logic [1:0] IDX_TYPE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [1:0] ST_CLAMPED = 2'd3;

  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
  } srsc_tag_t;

endpackage

>>> src/srsc_mul.sv
`timescale 1ns / 1ps
module srsc_mul import srsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       micro,
  input  logic [31:0]       num,
  input  logic [31:0]       den,
  output srsc_tag_t         out_tag,
  output logic [63:0]       prod
);

  logic        v0, v1, v2;
  logic        n0, n1, n2;
  logic [63:0] mag0;
  logic [31:0] nmag0;
  logic [63:0] plo, phi;
  logic [64:0] mid;
  logic [31:0] top_sum;
  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
    mag0 <= micro[63] ? (~micro + 64'd1) : micro;
    nmag0 <= num[31] ? (~num + 32'd1) : num;
    n0 <= micro[63] ^ num[31] ^ den[31];
    plo <= {32'd0, mag0[31:0]} * {32'd0, nmag0};
    phi <= {32'd0, mag0[63:32]} * {32'd0, nmag0};
    n1 <= n0;
    n2 <= n1;
    prod_r <= (top_sum != 32'd0) ? {64{1'b1}} : {mid[31:0], plo[31:0]};
  end

  always_comb begin
    mid = {33'd0, phi[31:0]} + {33'd0, plo[63:32]};
    top_sum = phi[63:32] + {31'd0, mid[32]};
  end

  assign out_tag = '{valid: v2, neg: n2, sat: 1'b0};
  assign prod = prod_r;

endmodule

>>> src/srsc_div.sv
`timescale 1ns / 1ps
module srsc_div import srsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  srsc_tag_t         in_tag,
  input  logic [63:0]       dividend,
  input  logic [DIV_W-1:0]  divisor,
  output srsc_tag_t         out_tag,
  output logic [QUO_W-1:0]  quotient
);

  srsc_tag_t         tag [0:QUO_W];
  logic [DIV_W-1:0]  rem [0:QUO_W];
  logic [63:0]       dvd [0:QUO_W];
  logic [QUO_W-1:0]  quo [0:QUO_W];
  logic [DIV_W:0]    trial [0:QUO_W-1];
  logic              ge [0:QUO_W-1];
  logic [64:0]       rounded;

  assign rounded = {1'b0, dividend} + {14'd0, divisor[DIV_W-1:1]};

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = {rem[k], dvd[k][63]};
      ge[k] = trial[k] >= {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        tag[k] <= '0;
      end
    end else begin
      tag[0] <= '{valid: in_tag.valid, neg: in_tag.neg, sat: rounded[64]};
      for (int k = 0; k < QUO_W; k++) begin
        tag[k+1] <= tag[k];
      end
    end
    dvd[0] <= rounded[63:0];
    rem[0] <= '0;
    quo[0] <= '0;
    for (int k = 0; k < QUO_W; k++) begin
      rem[k+1] <= ge[k] ? DIV_W'(trial[k] - {1'b0, divisor}) : trial[k][DIV_W-1:0];
      dvd[k+1] <= {dvd[k][62:0], 1'b0};
      quo[k+1] <= {quo[k][QUO_W-2:0], ge[k]};
    end
  end

  assign out_tag = tag[QUO_W];
  assign quotient = quo[QUO_W];

endmodule

>>> src/sensor_rational_scale_clamp_unit.sv
`timescale 1ns / 1ps
// Converts a signed 64-bit reading in micro-units into a raw value scaled by
// numerator / (denominator * 1e6), rounded half away from zero, offset and
// clamped to the selected value type.
// An item is taken at each rising edge with start high; busy is always low,
// so a new item may be given in every cycle. The result appears on raw_value
// and status for one cycle with done high, in the order of the items.
// Throughput is one item per cycle. A three-stage split multiplier feeds a
// 64-stage restoring divider, one quotient bit per stage. Registers are
// written through cfg_write, cfg_index and cfg_data; the user must write them
// only while no item is in flight, which the block leaves unchecked; a write
// to value_type keeps the low three bits. Reset empties the pipeline and
// returns the registers to numerator 1, denominator 1, offset 0 and type
// int16 signed. The receiver cannot stall: every result is shown once, for
// one cycle.
module sensor_rational_scale_clamp_unit import srsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] micro_value,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [32:0] raw_value,
  output logic [1:0]         status
);

  logic [31:0]       scale_numerator;
  logic [31:0]       scale_denominator;
  logic [31:0]       raw_offset;
  logic [2:0]        value_type;
  logic [DIV_W-1:0]  divisor;
  logic [31:0]       den_mag;

  srsc_tag_t         mul_tag, div_tag;
  logic [63:0]       prod;
  logic [63:0]       quotient;

  logic              v1, v2;
  logic signed [63:0] scaled;
  logic signed [64:0] summed;
  logic [63:0]       qsat;
  logic signed [64:0] lo_bound, hi_bound;
  logic              bad_type;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_numerator <= 32'd1;
      scale_denominator <= 32'd1;
      raw_offset <= 32'd0;
      value_type <= TYPE_I16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        IDX_NUM: scale_numerator <= cfg_data;
        IDX_DEN: scale_denominator <= cfg_data;
        IDX_OFF: raw_offset <= cfg_data;
        IDX_TYPE: value_type <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign den_mag = scale_denominator[31] ? (~scale_denominator + 32'd1) : scale_denominator;

  always_ff @(posedge clk) begin
    divisor <= {20'd0, den_mag} * {32'd0, MICRO_SCALE};
  end

  srsc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .in_valid(start),
    .micro   (micro_value),
    .num     (scale_numerator),
    .den     (scale_denominator),
    .out_tag (mul_tag),
    .prod    (prod)
  );

  srsc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (mul_tag),
    .dividend(prod),
    .divisor (divisor),
    .out_tag (div_tag),
    .quotient(quotient)
  );

  always_comb begin
    qsat = div_tag.sat ? {64{1'b1}} : quotient;
    if (qsat[63]) begin
      qsat = {1'b0, {63{1'b1}}};
    end
  end

  always_comb begin
    bad_type = 1'b0;
    case (value_type)
      TYPE_I16: begin
        lo_bound = -65'sd32767;
        hi_bound = 65'sd32767;
      end
      TYPE_U16: begin
        lo_bound = 65'sd0;
        hi_bound = 65'sd65534;
      end
      TYPE_I32: begin
        lo_bound = -65'sd2147483647;
        hi_bound = 65'sd2147483647;
      end
      TYPE_U32: begin
        lo_bound = 65'sd0;
        hi_bound = 65'sd4294967294;
      end
      default: begin
        lo_bound = 65'sd0;
        hi_bound = 65'sd0;
        bad_type = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= div_tag.valid;
      v2 <= v1;
      done <= v2;
    end
    scaled <= div_tag.neg ? -$signed(qsat) : $signed(qsat);
    summed <= {scaled[63], scaled} + {{33{raw_offset[31]}}, raw_offset};
    if (scale_denominator == 32'd0) begin
      raw_value <= '0;
      status <= ST_ZERO_DEN;
    end else if (bad_type) begin
      raw_value <= '0;
      status <= ST_BAD_TYPE;
    end else if (summed < lo_bound) begin
      raw_value <= lo_bound[32:0];
      status <= ST_CLAMPED;
    end else if (summed > hi_bound) begin
      raw_value <= hi_bound[32:0];
      status <= ST_CLAMPED;
    end else begin
      raw_value <= summed[32:0];
      status <= ST_OK;
    end
  end

endmodule
